@@ hdl/jasl_pkg.sv @@
package jasl_pkg;

   localparam int AXES = 7;
   localparam int AXIS_W = 3;
   localparam logic [AXIS_W-1:0] AXIS_NONE = 3'd7;

   localparam int MUL_W = 24;
   localparam int PROD_W = 2 * MUL_W;

   localparam int GAIN_W = 24;
   localparam int STEP_W = 28;
   localparam int TILT_W = 16;
   localparam int DELTA_W = 32;

   // Magnitudes below one in Q4.12 take the cubic shaping.
   localparam logic [TILT_W-1:0] TILT_ONE = 16'd4096;

   typedef logic [MUL_W-1:0] mul_opd_type;
   typedef logic [PROD_W-1:0] mul_prod_type;
   typedef logic signed [DELTA_W-1:0] delta_type;

endpackage

@@ hdl/jasl_mul.sv @@
module jasl_mul
   import jasl_pkg::*;
(
   input  logic         clock,
   input  mul_opd_type  opd_a,
   input  mul_opd_type  opd_b,
   output mul_prod_type prod_ff
);

   mul_prod_type prod_in;

   assign prod_in = opd_a * opd_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ hdl/jog_axis_slew_limiter_top.sv @@
// Jog axis slew limiter. Each accepted req_ beat is one hand-controller
// reading; unless new_session is set it produces exactly one rsp_ beat with
// the seven kept axis deltas (signed Q3.28) and done_res. The B button and
// the pad choose one axis; its request is the tilt (Q4.12) cubed times gain
// when |tilt| < 1, or tilt times gain otherwise, and every delta moves toward
// its request by at most max_change. One shared 24x24 registered multiplier
// builds the request in up to four passes (square, cube, low and high gain
// partial products), then one shared subtract/compare unit slews the axes
// one per cycle. A cubic request takes all four passes, a linear one the
// single tilt-times-gain pass, and a zero request (stop latched or no axis
// chosen) goes straight to the slew; req_ready is low while a reading is in
// work. A new_session beat only clears the latches. The result sits in an
// output register, so it may wait for rsp_ready while the next reading is
// accepted; that reading stalls only at its final load.
// Registers: gain at byte 0 (Q0.24), max_change at byte 4 (Q3.28).
module jog_axis_slew_limiter_top
   import jasl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_new_session,
   input  logic                      req_button_a,
   input  logic                      req_button_b,
   input  logic                      req_pad_left,
   input  logic                      req_pad_right,
   input  logic                      req_pad_up,
   input  logic                      req_pad_down,
   input  logic signed [TILT_W-1:0]  req_tilt,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DELTA_W-1:0] rsp_delta_x,
   output logic signed [DELTA_W-1:0] rsp_delta_y,
   output logic signed [DELTA_W-1:0] rsp_delta_z,
   output logic signed [DELTA_W-1:0] rsp_delta_rot_a,
   output logic signed [DELTA_W-1:0] rsp_delta_rot_b,
   output logic signed [DELTA_W-1:0] rsp_delta_rot_c,
   output logic signed [DELTA_W-1:0] rsp_delta_grip,
   output logic                      rsp_done_res,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;
   localparam logic [3:0] S_CUBE = 4'd2;
   localparam logic [3:0] S_GLO  = 4'd3;
   localparam logic [3:0] S_GHI  = 4'd4;
   localparam logic [3:0] S_LIN  = 4'd5;
   localparam logic [3:0] S_RES  = 4'd6;
   localparam logic [3:0] S_SLEW = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

   // Register map, decoded on the word address bit.
   localparam logic REG_GAIN = 1'b0;
   localparam logic REG_STEP = 1'b1;

   // Fixed-priority axis choice: B picks the rotation group, down is the grip.
   function automatic logic [AXIS_W-1:0] pick_axis(input logic b, input logic left,
                                                   input logic right, input logic up,
                                                   input logic down);
      logic [AXIS_W-1:0] ax;
      ax = AXIS_NONE;
      if (!b && left) ax = 3'd0;
      else if (!b && right) ax = 3'd1;
      else if (!b && up) ax = 3'd2;
      else if (b && left) ax = 3'd3;
      else if (b && right) ax = 3'd4;
      else if (b && up) ax = 3'd5;
      else if (down) ax = 3'd6;
      return ax;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      gain_in = gain_ff;
      step_in = step_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_GAIN: gain_in = pwdata[GAIN_W-1:0];
            REG_STEP: step_in = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_GAIN: prdata = {{(32-GAIN_W){1'b0}}, gain_ff};
         REG_STEP: prdata = {{(32-STEP_W){1'b0}}, step_ff};
         default:  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath state
   // ---------------------------------------------------------------------
   logic [3:0]        state_ff, state_in;
   logic              a_rel_ff, a_rel_in;
   logic              stop_ff, stop_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic [AXIS_W-1:0] idx_ff, idx_in;
   logic              neg_ff, neg_in;
   logic              small_ff, small_in;
   logic [TILT_W-1:0] mag_ff, mag_in;
   logic [11:0]       cube_hi_ff, cube_hi_in;
   mul_prod_type      plo_ff, plo_in;
   delta_type         req_ff, req_in;
   logic              nz_ff, nz_in;
   delta_type         delta_ff [AXES];
   delta_type         delta_in [AXES];

   logic              rsp_valid_ff, rsp_valid_in;
   delta_type         out_ff [AXES];
   delta_type         out_in [AXES];
   logic              done_ff, done_in;

   // Shared multiplier.
   mul_opd_type       opd_a, opd_b;
   mul_prod_type      prod_ff;

   jasl_mul u_mul (
      .clock   (clock),
      .opd_a   (opd_a),
      .opd_b   (opd_b),
      .prod_ff (prod_ff)
   );

   logic              in_beat;
   logic              out_free;
   logic [TILT_W:0]   tilt_abs;
   logic [AXIS_W-1:0] pick;
   logic              req_live;

   // Request assembly.
   logic [59:0]       sum60;
   logic [DELTA_W-1:0] req_mag;

   // Shared slew unit.
   delta_type         cur;
   delta_type         tgt;
   logic [DELTA_W:0]  diff;
   logic [DELTA_W:0]  adiff;
   logic              below;
   delta_type         nxt;

   assign req_ready = (state_ff == S_IDLE);
   assign in_beat   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign tilt_abs = req_tilt[TILT_W-1] ? (17'd0 - {req_tilt[TILT_W-1], req_tilt})
                                        : {1'b0, req_tilt};
   assign pick = pick_axis(req_button_b, req_pad_left, req_pad_right, req_pad_up,
                           req_pad_down);

   // Operand select for each multiply pass.
   always_comb begin
      opd_a = '0;
      opd_b = '0;
      case (state_ff)
         S_SQ: begin
            opd_a = MUL_W'(mag_ff);
            opd_b = MUL_W'(mag_ff);
         end
         S_CUBE: begin
            opd_a = prod_ff[MUL_W-1:0];
            opd_b = MUL_W'(mag_ff);
         end
         S_GLO: begin
            opd_a = prod_ff[MUL_W-1:0];
            opd_b = gain_ff;
         end
         S_GHI: begin
            opd_a = MUL_W'(cube_hi_ff);
            opd_b = gain_ff;
         end
         S_LIN: begin
            opd_a = MUL_W'(mag_ff);
            opd_b = gain_ff;
         end
         default: ;
      endcase
   end

   // Cubic path: (phi << 24) + plo is the 60-bit cube times gain; keep >> 32.
   // Linear path: product >> 8. Neither can exceed the signed 32-bit range.
   assign sum60   = {prod_ff[35:0], 24'd0} + {12'd0, plo_ff};
   assign req_mag = small_ff ? {4'd0, sum60[59:32]} : prod_ff[39:8];

   // One axis per cycle: step toward the target, snap when within max_change.
   assign cur   = delta_ff[idx_ff];
   assign tgt   = (idx_ff == axis_ff) ? req_ff : '0;
   assign diff  = {cur[DELTA_W-1], cur} - {tgt[DELTA_W-1], tgt};
   assign adiff = diff[DELTA_W] ? ((DELTA_W+1)'(0) - diff) : diff;
   assign below = adiff < {{(DELTA_W+1-STEP_W){1'b0}}, step_ff};
   assign nxt   = below ? tgt
                : diff[DELTA_W] ? (cur + {{(DELTA_W-STEP_W){1'b0}}, step_ff})
                : (cur - {{(DELTA_W-STEP_W){1'b0}}, step_ff});

   always_comb begin
      state_in     = state_ff;
      a_rel_in     = a_rel_ff;
      stop_in      = stop_ff;
      axis_in      = axis_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      small_in     = small_ff;
      mag_in       = mag_ff;
      cube_hi_in   = cube_hi_ff;
      plo_in       = plo_ff;
      req_in       = req_ff;
      nz_in        = nz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      done_in      = done_ff;
      req_live     = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         delta_in[i] = delta_ff[i];
         out_in[i]   = out_ff[i];
      end

      case (state_ff)
         S_IDLE: begin
            if (in_beat) begin
               if (req_new_session) begin
                  a_rel_in = 1'b0;
                  stop_in  = 1'b0;
               end else begin
                  // Latch release first, then a press in the same reading stops.
                  a_rel_in = a_rel_ff || !req_button_a;
                  stop_in  = stop_ff || (a_rel_in && req_button_a);
                  req_live = !stop_in && (pick != AXIS_NONE);
                  axis_in  = pick;
                  idx_in   = '0;
                  nz_in    = 1'b0;
                  neg_in   = req_tilt[TILT_W-1];
                  mag_in   = tilt_abs[TILT_W-1:0];
                  small_in = tilt_abs[TILT_W-1:0] < TILT_ONE;
                  req_in   = '0;
                  if (!req_live) state_in = S_SLEW;
                  else if (small_in) state_in = S_SQ;
                  else state_in = S_LIN;
               end
            end
         end
         S_SQ:   state_in = S_CUBE;
         S_CUBE: state_in = S_GLO;
         S_GLO: begin
            cube_hi_in = prod_ff[35:24];
            state_in   = S_GHI;
         end
         S_GHI: begin
            plo_in   = prod_ff;
            state_in = S_RES;
         end
         S_LIN:  state_in = S_RES;
         S_RES: begin
            req_in   = neg_ff ? (DELTA_W'(0) - req_mag) : req_mag;
            state_in = S_SLEW;
         end
         S_SLEW: begin
            delta_in[idx_ff] = nxt;
            nz_in            = nz_ff || (nxt != '0);
            idx_in           = idx_ff + AXIS_W'(1);
            if (idx_ff == LAST_AXIS) state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the previous result has left the output register.
            if (out_free) begin
               for (int i = 0; i < AXES; i++) out_in[i] = delta_ff[i];
               done_in      = stop_ff && !nz_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_rel_ff     <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= 24'd50332;
         step_ff      <= 28'd26844;
         for (int i = 0; i < AXES; i++) delta_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         a_rel_ff     <= a_rel_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         step_ff      <= step_in;
         for (int i = 0; i < AXES; i++) delta_ff[i] <= delta_in[i];
      end
   end

   always_ff @(posedge clock) begin
      axis_ff    <= axis_in;
      idx_ff     <= idx_in;
      neg_ff     <= neg_in;
      small_ff   <= small_in;
      mag_ff     <= mag_in;
      cube_hi_ff <= cube_hi_in;
      plo_ff     <= plo_in;
      req_ff     <= req_in;
      nz_ff      <= nz_in;
      done_ff    <= done_in;
      for (int i = 0; i < AXES; i++) out_ff[i] <= out_in[i];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_delta_x     = out_ff[0];
   assign rsp_delta_y     = out_ff[1];
   assign rsp_delta_z     = out_ff[2];
   assign rsp_delta_rot_a = out_ff[3];
   assign rsp_delta_rot_b = out_ff[4];
   assign rsp_delta_rot_c = out_ff[5];
   assign rsp_delta_grip  = out_ff[6];
   assign rsp_done_res    = done_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_busy_after_reading: assert property (@(posedge clock) disable iff (reset)
      (in_beat && !req_new_session) |=> !req_ready)
      else $error("reading accepted but block still ready");

   a_stop_no_request: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SLEW && stop_ff) |-> (req_ff == '0))
      else $error("request live while stop latched");

   a_done_all_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_delta_x == '0 && rsp_delta_y == '0 &&
         rsp_delta_z == '0 && rsp_delta_rot_a == '0 && rsp_delta_rot_b == '0 &&
         rsp_delta_rot_c == '0 && rsp_delta_grip == '0))
      else $error("done raised with a nonzero delta");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_delta_x)))
      else $error("waiting result overwritten");

endmodule
